/* rtl/cle_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and character codes for the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

    // Result kinds, as carried on m_tuser
    typedef enum logic [3:0] {
        KIND_ECHO    = 4'd0,
        KIND_BELL    = 4'd1,
        KIND_ERASE   = 4'd2,
        KIND_NLEND   = 4'd3,
        KIND_SILENT  = 4'd4,
        KIND_DATA    = 4'd5,
        KIND_NONE    = 4'd6,
        KIND_EOF     = 4'd7,
        KIND_IGNORED = 4'd8
    } kind_t;

    // Input commands, as carried on s_tuser[0]
    localparam logic CMD_CHAR    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    // Control characters
    localparam logic [7:0] CH_EOT = 8'h04;  // Ctrl-D
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NAK = 8'h15;  // Ctrl-U
    localparam logic [7:0] CH_DEL = 8'h7F;

    localparam int ERASE_W   = 9;
    localparam int ERASE_MAX = 511;

endpackage : cle_pkg
`default_nettype wire

/* rtl/cle_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cle_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule : cle_ram
`default_nettype wire

/* rtl/console_line_editor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// console_line_editor
// Cooked-mode line editor: stores and echoes received characters, handles
// rub-out, line kill and line end, and reads a finished line back on request.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                           tuser
//  s_        in   [7:0] char_in                   [0] command, [1] rx_error
//  m_        out  [7:0] value, [16:8] erase_count [3:0] kind
//
//  One word accepted per cycle unless m_ stalls; each result passes through
//  the decode and result registers, taking line bytes from the store's read port.
//  Reset clears the edit and read state at once; the line store needs no
//  clearing pass, since only entries of the current line are ever read.
//  A stall on m_ holds the result and decode registers and drops s_tready.
// ----------------------------------------------------------------------------
module console_line_editor
    import cle_pkg::*;
#(
    parameter int LINE_CHARS = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    input  wire logic [1:0]  s_tuser,   // [0] command, [1] rx_error
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] value, [16:8] erase_count
    output logic [3:0]       m_tuser    // [3:0] kind
);

    localparam int AW = $clog2(LINE_CHARS);
    localparam int CW = $clog2(LINE_CHARS + 1);
    localparam int XW = (CW > ERASE_W) ? CW : ERASE_W;

    // Edit and read state
    logic [CW-1:0] fill_count_reg, fill_count_next;
    logic [CW-1:0] read_pos_reg, read_pos_next;
    logic [CW-1:0] chars_left_reg, chars_left_next;
    logic          eof_pending_reg, eof_pending_next;

    // Decode stage
    logic               p1_valid_reg;
    kind_t              p1_kind_reg, p1_kind_next;
    logic [7:0]         p1_value_reg, p1_value_next;
    logic [ERASE_W-1:0] p1_erase_reg, p1_erase_next;
    logic               p1_ram_reg, p1_ram_next;

    // Result stage
    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [7:0]         out_value_reg;
    logic [ERASE_W-1:0] out_erase_reg;

    logic          s_accept;
    logic          p1_move;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [7:0]    ram_rdata;
    logic [XW-1:0] fill_x;
    logic [7:0]    char_in;
    logic          command;
    logic          rx_error;

    assign char_in  = s_tdata;
    assign command  = s_tuser[0];
    assign rx_error = s_tuser[1];

    assign p1_move  = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_move;
    assign s_accept = s_tvalid && s_tready;

    assign fill_x = XW'(fill_count_reg);

    always_comb begin
        fill_count_next  = fill_count_reg;
        read_pos_next    = read_pos_reg;
        chars_left_next  = chars_left_reg;
        eof_pending_next = eof_pending_reg;
        p1_kind_next     = KIND_NONE;
        p1_value_next    = 8'd0;
        p1_erase_next    = '0;
        p1_ram_next      = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = fill_count_reg[AW-1:0];
        ram_wdata        = char_in;
        ram_re           = 1'b0;

        if (command == CMD_REQUEST) begin
            if (chars_left_reg != '0 && read_pos_reg < CW'(LINE_CHARS)) begin
                p1_kind_next    = KIND_DATA;
                p1_ram_next     = 1'b1;
                ram_re          = s_accept;
                read_pos_next   = read_pos_reg + CW'(1);
                chars_left_next = chars_left_reg - CW'(1);
            end else if (eof_pending_reg) begin
                p1_kind_next     = KIND_EOF;
                eof_pending_next = 1'b0;
            end else begin
                p1_kind_next = KIND_NONE;
            end
        end else if (chars_left_reg != '0 || eof_pending_reg) begin
            p1_kind_next = KIND_IGNORED;
        end else if (rx_error || char_in == CH_EOT) begin
            p1_kind_next     = KIND_SILENT;
            eof_pending_next = (fill_count_reg == '0);
            chars_left_next  = fill_count_reg;
            read_pos_next    = '0;
            fill_count_next  = '0;
        end else if (char_in inside {CH_CR, CH_LF}) begin
            // Fill never exceeds LINE_CHARS-1, so the newline always fits
            p1_kind_next    = KIND_NLEND;
            p1_value_next   = CH_LF;
            ram_we          = s_accept;
            ram_wdata       = CH_LF;
            chars_left_next = fill_count_reg + CW'(1);
            read_pos_next   = '0;
            fill_count_next = '0;
        end else if (char_in inside {CH_DEL, CH_BS}) begin
            p1_kind_next = KIND_ERASE;
            if (fill_count_reg != '0) begin
                fill_count_next = fill_count_reg - CW'(1);
                p1_erase_next   = ERASE_W'(1);
            end
        end else if (char_in == CH_NAK) begin
            p1_kind_next    = KIND_ERASE;
            fill_count_next = '0;
            p1_erase_next   = (fill_x > XW'(ERASE_MAX)) ? ERASE_W'(ERASE_MAX)
                                                        : fill_x[ERASE_W-1:0];
        end else if (fill_count_reg >= CW'(LINE_CHARS - 1)) begin
            p1_kind_next = KIND_BELL;
        end else begin
            p1_kind_next    = KIND_ECHO;
            p1_value_next   = char_in;
            ram_we          = s_accept;
            fill_count_next = fill_count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg  <= '0;
            read_pos_reg    <= '0;
            chars_left_reg  <= '0;
            eof_pending_reg <= 1'b0;
        end else if (s_accept) begin
            fill_count_reg  <= fill_count_next;
            read_pos_reg    <= read_pos_next;
            chars_left_reg  <= chars_left_next;
            eof_pending_reg <= eof_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_kind_reg  <= p1_kind_next;
            p1_value_reg <= p1_value_next;
            p1_erase_reg <= p1_erase_next;
            p1_ram_reg   <= p1_ram_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    // Take the line byte from the read port when the word came from the store
    always_ff @(posedge aclk) begin
        if (p1_move) begin
            out_kind_reg  <= p1_kind_reg;
            out_value_reg <= p1_ram_reg ? ram_rdata : p1_value_reg;
            out_erase_reg <= p1_erase_reg;
        end
    end

    cle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CHARS)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (read_pos_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_erase_reg, out_value_reg};

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CW'(LINE_CHARS - 1))
        else $error("fill count beyond store size");

    a_pending_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(chars_left_reg != '0 && eof_pending_reg))
        else $error("eof pending with unread line characters");

    a_read_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, read_pos_reg} + {1'b0, chars_left_reg}) <= (CW+1)'(LINE_CHARS))
        else $error("read position and remaining count overrun the line");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_ECHO && m_tuser != KIND_DATA
         && m_tuser != KIND_NLEND) |-> (m_tdata[7:0] == 8'd0))
        else $error("nonzero value on a result kind without data");

    a_erase_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_ERASE) |-> (m_tdata[16:8] == 9'd0))
        else $error("nonzero erase count outside an erase result");
`endif

endmodule : console_line_editor
`default_nettype wire

/* dv/cle_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cle_checker
// Watches both stream channels of the console line editor. Every word taken
// on s_ is run through a cycle-free model of the editor, and the result it
// should produce is queued. Every word leaving on m_ is compared field by
// field against the oldest queued result.
// ----------------------------------------------------------------------------
module cle_checker
    import cle_pkg::*;
#(
    parameter int LINE_CHARS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_in
    input  logic [1:0]  s_tuser,    // [0] command, [1] rx_error
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [7:0] value, [16:8] erase_count
    input  logic [3:0]  m_tuser,    // [3:0] kind
    output int          fail_count,
    output int          results_due
);

    typedef struct packed {
        kind_t                kind;
        logic [7:0]           value;
        logic [ERASE_W-1:0]   erase_count;
    } editor_result_t;

    editor_result_t due_results[$];

    // Model state of the editor
    logic [7:0]  line_buf [LINE_CHARS];
    int unsigned fill_cnt;
    int unsigned read_idx;
    int unsigned unread_cnt;
    bit          eof_flag;

    // Advance the model by one word and return the result it causes
    function automatic editor_result_t next_result(input logic cmd, input logic [7:0] ch,
                                                   input logic err);
        editor_result_t res;
        int unsigned    n;
        res.kind        = KIND_IGNORED;
        res.value       = 8'h00;
        res.erase_count = '0;
        if (cmd == CMD_REQUEST) begin
            if (unread_cnt != 0 && read_idx < LINE_CHARS) begin
                res.kind  = KIND_DATA;
                res.value = line_buf[read_idx];
                read_idx++;
                unread_cnt--;
            end else if (eof_flag) begin
                eof_flag = 1'b0;
                res.kind = KIND_EOF;
            end else begin
                res.kind = KIND_NONE;
            end
        end else if (unread_cnt != 0 || eof_flag) begin
            // drop input while a finished line waits to be read
            res.kind = KIND_IGNORED;
        end else if (err || ch == CH_EOT) begin
            if (fill_cnt == 0)
                eof_flag = 1'b1;
            unread_cnt = fill_cnt;
            read_idx   = 0;
            fill_cnt   = 0;
            res.kind   = KIND_SILENT;
        end else if (ch == CH_CR || ch == CH_LF) begin
            n = fill_cnt;
            if (n < LINE_CHARS) begin
                line_buf[n] = CH_LF;
                n++;
            end
            unread_cnt = n;
            read_idx   = 0;
            fill_cnt   = 0;
            res.kind   = KIND_NLEND;
            res.value  = CH_LF;
        end else if (ch == CH_DEL || ch == CH_BS) begin
            res.kind = KIND_ERASE;
            if (fill_cnt > 0) begin
                fill_cnt--;
                res.erase_count = ERASE_W'(1);
            end
        end else if (ch == CH_NAK) begin
            res.kind        = KIND_ERASE;
            res.erase_count = ERASE_W'((fill_cnt > ERASE_MAX) ? ERASE_MAX : fill_cnt);
            fill_cnt        = 0;
        end else if (fill_cnt >= LINE_CHARS - 1) begin
            // keep the last slot for the newline
            res.kind = KIND_BELL;
        end else begin
            line_buf[fill_cnt] = ch;
            fill_cnt++;
            res.kind  = KIND_ECHO;
            res.value = ch;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        editor_result_t exp_res;
        if (!aresetn) begin
            fill_cnt   = 0;
            read_idx   = 0;
            unread_cnt = 0;
            eof_flag   = 1'b0;
            fail_count = 0;
            due_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                due_results.push_back(next_result(s_tuser[0], s_tdata, s_tuser[1]));
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $error("result word with nothing expected: kind %0d value %0d",
                           m_tuser, m_tdata[7:0]);
                    fail_count++;
                end else begin
                    exp_res = due_results.pop_front();
                    if (m_tuser !== exp_res.kind) begin
                        $error("kind: expected %0d, got %0d", exp_res.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[7:0] !== exp_res.value) begin
                        $error("value: expected %0d, got %0d", exp_res.value, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[16:8] !== exp_res.erase_count) begin
                        $error("erase_count: expected %0d, got %0d",
                               exp_res.erase_count, m_tdata[16:8]);
                        fail_count++;
                    end
                    if (m_tdata[23:17] !== 7'd0) begin
                        $error("tdata padding: expected 0, got %0d", m_tdata[23:17]);
                        fail_count++;
                    end
                end
            end
        end
        results_due <= due_results.size();
    end

endmodule : cle_checker

/* dv/tb_console_line_editor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_console_line_editor
// Drives the console line editor with a short directed sequence covering
// rub-out, line kill, every line end, pending-line and end-of-file handling,
// then with random edited lines that are read back, one line that overflows
// the store, and a long output stall. Results are checked by cle_checker.
// ----------------------------------------------------------------------------
module tb_console_line_editor;
    import cle_pkg::*;

    localparam int LINE_CHARS  = 256;
    localparam int TOTAL_WORDS = 1300;
    localparam int HOLD_CYCLES = 400;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [1:0]  s_tuser  = 2'b00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;

    int fail_count;
    int results_due;
    int words_sent   = 0;
    int phase        = 0;
    int tx_idle_pct  = 7;
    int rx_idle_pct  = 77;

    console_line_editor #(
        .LINE_CHARS (LINE_CHARS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cle_checker #(
        .LINE_CHARS (LINE_CHARS)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off once the last phase starts
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (phase == 2 && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic set_phase(input int p);
        phase = p;
        case (p)
            0: begin
                tx_idle_pct = 7;
                rx_idle_pct = 77;
            end
            1: begin
                tx_idle_pct = 77;
                rx_idle_pct = 7;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one word and hold it until accepted; counted words add to the total
    task automatic send_word(input logic cmd, input logic [7:0] ch, input logic err,
                             input bit counted);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= {err, cmd};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (counted)
            words_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_word(CMD_CHAR, ch, 1'b0, 1'b1);
    endtask

    task automatic send_request();
        send_word(CMD_REQUEST, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    endtask

    // Edit a line at random, finish it, poke it while pending, then read it back
    task automatic random_line(input int edits);
        int         fill;
        int         left;
        int         eof_due;
        int         r;
        logic [7:0] ch;
        fill = 0;
        repeat (edits) begin
            r = $urandom_range(99);
            if (r < 6) begin
                send_char($urandom_range(1) ? CH_BS : CH_DEL);
                if (fill > 0)
                    fill--;
            end else if (r < 8) begin
                send_char(CH_NAK);
                fill = 0;
            end else if (r < 10) begin
                send_request();
            end else begin
                ch = 8'($urandom_range(255));
                // steer control codes off to ordinary characters
                if (ch == CH_EOT || ch == CH_BS || ch == CH_LF || ch == CH_CR ||
                    ch == CH_NAK || ch == CH_DEL)
                    ch = ch ^ 8'h40;
                send_char(ch);
                if (fill < LINE_CHARS - 1)
                    fill++;
            end
        end
        r = $urandom_range(99);
        if (r < 40 || r >= 70 && r < 70) begin
            send_char(CH_CR);
            left    = fill + 1;
            eof_due = 0;
        end else if (r < 70) begin
            send_char(CH_LF);
            left    = fill + 1;
            eof_due = 0;
        end else begin
            if (r < 85)
                send_char(CH_EOT);
            else
                send_word(CMD_CHAR, 8'($urandom_range(255)), 1'b1, 1'b1);
            left    = fill;
            eof_due = (fill == 0);
        end
        repeat ($urandom_range(2))
            send_word(CMD_CHAR, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
        repeat (left + eof_due + $urandom_range(1))
            send_request();
    endtask

    // Overflow the store, rub out, refill to the bell and read all 256 back
    task automatic full_line();
        repeat (LINE_CHARS + 2)
            send_char(8'($urandom_range(8'h80, 8'hFF)));
        send_char(CH_DEL);
        repeat (3)
            send_char(8'($urandom_range(8'h80, 8'hFF)));
        send_char(CH_CR);
        repeat (LINE_CHARS + 1)
            send_request();
    endtask

    initial begin
        bit full_done;
        full_done = 1'b0;
        set_phase(0);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-line cases, edits, every line end, pending and eof
        send_request();
        send_char(CH_BS);
        send_char(CH_DEL);
        send_char(CH_NAK);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h41);
        send_char(CH_BS);
        send_char(CH_NAK);
        send_char(8'h7E);
        send_char(CH_DEL);
        send_char(8'h80);
        send_char(CH_CR);
        send_word(CMD_CHAR, 8'h61, 1'b0, 1'b0);
        send_word(CMD_REQUEST, 8'hFF, 1'b1, 1'b1);
        send_request();
        send_request();
        send_char(CH_EOT);
        send_word(CMD_CHAR, 8'h41, 1'b1, 1'b0);
        send_request();
        send_request();
        send_char(8'h55);
        send_word(CMD_CHAR, CH_CR, 1'b1, 1'b1);
        send_request();
        send_word(CMD_CHAR, CH_LF, 1'b1, 1'b1);
        send_request();
        send_char(CH_LF);
        send_request();

        while (words_sent < TOTAL_WORDS) begin
            if (words_sent >= 2 * TOTAL_WORDS / 3)
                set_phase(2);
            else if (words_sent >= TOTAL_WORDS / 3)
                set_phase(1);
            if (phase == 2 && !full_done) begin
                full_line();
                full_done = 1'b1;
            end
            random_line(($urandom_range(99) < 85) ? $urandom_range(0, 12)
                                                  : $urandom_range(13, 40));
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule : tb_console_line_editor
